@@ rtl/core/bocm_pkg.sv @@
// Shared types, constants and helpers for the complement match unit.
package bocm_pkg;

  // Fixed field widths
  localparam int BASE_W     = 2;
  localparam int LEN_W      = 6;
  localparam int POS_W      = 16;
  localparam int K_W        = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  // Slots reduced per group in the first tree level
  localparam int GROUP = 8;

  // A base and its complement always sum to 3
  localparam logic [BASE_W-1:0] COMPLEMENT = 2'b11;

  // Register select, taken from paddr[3]
  localparam logic REG_SAMPLE_BASES  = 1'b0;
  localparam logic REG_SAMPLE_LENGTH = 1'b1;

  // One closing window: its score and its offset back from the current base
  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] score;
    logic [K_W-1:0]   k;
  } cand_t;

  // Per-base controls for the window bank
  typedef struct packed {
    logic take;   // a base is transferred this cycle
    logic add;    // the base is inside the index range
    logic last;   // final base of the sequence
    logic load;   // offer register may advance
  } bank_ctl_t;

  // Higher score wins; on equal scores the later start (smaller offset) wins
  function automatic cand_t cand_pick(input cand_t a, input cand_t b);
    cand_t r;
    if (!b.valid) begin
      r = a;
    end else if (!a.valid) begin
      r = b;
    end else if (b.score > a.score) begin
      r = b;
    end else if (a.score > b.score) begin
      r = a;
    end else begin
      r = (b.k < a.k) ? b : a;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/bocm_if.sv @@
// Stream interfaces for sequence bases in and match results out.
interface bocm_base_if;
  logic                       valid;
  logic                       ready;
  logic [bocm_pkg::BASE_W-1:0] base;
  logic                       last_base;

  modport source (output valid, base, last_base, input ready);
  modport sink   (input valid, base, last_base, output ready);
endinterface

interface bocm_result_if;
  logic                       valid;
  logic                       ready;
  logic [bocm_pkg::POS_W-1:0] best_index;
  logic                       index_overflow;

  modport source (output valid, best_index, index_overflow, input ready);
  modport sink   (input valid, best_index, index_overflow, output ready);
endinterface

@@ rtl/core/bocm_window_bank.sv @@
// Window slot bank: per-slot scores updated in parallel, closing windows registered as offers.
module bocm_window_bank #(
  parameter int SAMPLE_MAX = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bocm_pkg::bank_ctl_t                    ctl,
  input  logic [((SAMPLE_MAX > 1) ? $clog2(SAMPLE_MAX) : 1)-1:0] pmod,
  input  logic [bocm_pkg::BASE_W-1:0]            base,
  input  logic [bocm_pkg::LEN_W-1:0]             len,
  input  logic [bocm_pkg::CFG_DATA_W-1:0]        sample_bases,
  output bocm_pkg::cand_t [SAMPLE_MAX-1:0]       cand
);

  localparam int KW = (SAMPLE_MAX > 1) ? $clog2(SAMPLE_MAX) : 1;

  logic [SAMPLE_MAX-1:0]     active;
  logic [bocm_pkg::LEN_W-1:0] score [SAMPLE_MAX];
  logic                      len_zero;

  assign len_zero = (len == '0);

  for (genvar s = 0; s < SAMPLE_MAX; s++) begin : g_slot
    logic [KW:0]                kw;
    logic [KW-1:0]              k;
    logic [bocm_pkg::LEN_W-1:0] kx;
    logic [bocm_pkg::BASE_W-1:0] sb;
    logic                       k_zero;
    logic                       open;
    logic                       act0;
    logic [bocm_pkg::LEN_W-1:0] score0;
    logic                       hit;
    logic [bocm_pkg::LEN_W-1:0] sc1;
    logic                       close;
    bocm_pkg::cand_t            offer;

    // Offset of this slot's window from the current base
    always_comb begin
      if (pmod >= KW'(s)) begin
        kw = {1'b0, pmod} - (KW+1)'(s);
      end else begin
        kw = {1'b0, pmod} + (KW+1)'(SAMPLE_MAX - s);
      end
    end
    assign k      = kw[KW-1:0];
    assign kx     = bocm_pkg::LEN_W'(k);
    assign sb     = bocm_pkg::BASE_W'(sample_bases >> {kx, 1'b0});
    assign k_zero = (k == '0);

    // Window update for this base
    assign open   = ctl.add && k_zero && !len_zero;
    assign act0   = open || active[s];
    assign score0 = open ? '0 : score[s];
    assign hit    = ctl.add && (kx < len) && ((base ^ sb) == bocm_pkg::COMPLEMENT);
    assign sc1    = score0 + bocm_pkg::LEN_W'(hit);
    assign close  = ctl.last || ((kx + 1'b1) >= len);

    // An empty sample still offers the newest start with score zero
    always_comb begin
      offer.valid = ctl.take && ((act0 && close) || (ctl.add && k_zero && len_zero));
      offer.score = act0 ? sc1 : '0;
      offer.k     = bocm_pkg::K_W'(k);
    end

    // Slot state
    always_ff @(posedge clk) begin
      if (rst) begin
        active[s] <= 1'b0;
      end else if (ctl.take) begin
        active[s] <= act0 && !close;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.take) begin
        score[s] <= close ? '0 : sc1;
      end
    end

    // Offer register
    always_ff @(posedge clk) begin
      if (rst) begin
        cand[s] <= '0;
      end else if (ctl.load) begin
        cand[s] <= offer;
      end
    end
  end

endmodule

@@ rtl/core/best_offset_complement_match_unit.sv @@
// Top level of the complement match unit: config port, position tracking, best-start tracking.
// Takes one 2-bit base per cycle and scores every start index against the configured sample
// (complement matches, A-T and C-G) in a bank of SAMPLE_MAX window slots that all update in
// the same cycle, so a base can be transferred in every cycle. Closing windows are reduced to
// one candidate through two registered levels; a sequence's result passes the offer, group
// and result registers after its last base is transferred and is held until taken. Input ready
// drops only while a result waits at the output and a second final base has reached the
// merge stage. Bases past index min(SEQUENCE_MAX-1, 65535) are ignored and flag an overflow.
// Registers (64-bit APB): sample_bases at 0x0, sample_length at 0x8.
module best_offset_complement_match_unit #(
  parameter int SAMPLE_MAX   = 32,
  parameter int SEQUENCE_MAX = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  bocm_base_if.sink                           seq_in,
  bocm_result_if.source                       res_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bocm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [bocm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [bocm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int KW = (SAMPLE_MAX > 1) ? $clog2(SAMPLE_MAX) : 1;
  localparam int NG = (SAMPLE_MAX + bocm_pkg::GROUP - 1) / bocm_pkg::GROUP;
  localparam logic [bocm_pkg::POS_W-1:0] IDX_CAP =
    bocm_pkg::POS_W'(((SEQUENCE_MAX - 1) > 65535) ? 65535 : (SEQUENCE_MAX - 1));

  // Configuration registers
  logic [bocm_pkg::CFG_DATA_W-1:0] sample_bases;
  logic [bocm_pkg::LEN_W-1:0]      sample_length;
  logic [bocm_pkg::LEN_W-1:0]      len;
  logic                            cfg_write;

  // Position tracking
  logic [bocm_pkg::POS_W-1:0] position;
  logic [KW-1:0]              pmod;
  logic                       saturated;
  logic                       overflow_seen;

  // Pipeline control
  logic take;
  logic a_stall;
  logic b_stall;
  logic merge;

  // Offer stage
  logic                       a_valid;
  logic                       a_last;
  logic                       a_ovf;
  logic [bocm_pkg::POS_W-1:0] a_pos;
  bocm_pkg::cand_t [SAMPLE_MAX-1:0] a_cand;
  bocm_pkg::bank_ctl_t        bank_ctl;

  // Group stage
  logic                       b_valid;
  logic                       b_last;
  logic                       b_ovf;
  logic [bocm_pkg::POS_W-1:0] b_pos;
  bocm_pkg::cand_t            b_grp [NG];
  bocm_pkg::cand_t            grp_c [NG];

  // Best tracking
  bocm_pkg::cand_t            batch;
  logic                       upd;
  logic [bocm_pkg::POS_W-1:0] best_start;
  logic [bocm_pkg::POS_W-1:0] best_start_next;
  logic [bocm_pkg::LEN_W-1:0] best_score;
  logic                       best_seen;

  // Output register
  logic                       res_valid;
  logic [bocm_pkg::POS_W-1:0] res_index;
  logic                       res_ovf;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_bases  <= '0;
      sample_length <= '0;
    end else if (cfg_write) begin
      if (paddr[3] == bocm_pkg::REG_SAMPLE_LENGTH) begin
        sample_length <= pwdata[bocm_pkg::LEN_W-1:0];
      end else begin
        sample_bases <= pwdata;
      end
    end
  end

  assign prdata = (paddr[3] == bocm_pkg::REG_SAMPLE_LENGTH) ?
                  bocm_pkg::CFG_DATA_W'(sample_length) : sample_bases;

  assign len = (sample_length > bocm_pkg::LEN_W'(SAMPLE_MAX)) ?
               bocm_pkg::LEN_W'(SAMPLE_MAX) : sample_length;

  // Handshake and stalls
  assign b_stall      = b_valid && b_last && res_valid && !res_out.ready;
  assign a_stall      = a_valid && b_stall;
  assign seq_in.ready = !a_stall;
  assign take         = seq_in.valid && !a_stall;
  assign merge        = b_valid && !b_stall;

  // Position, saturation and overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      pmod          <= '0;
      saturated     <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (take) begin
      if (seq_in.last_base) begin
        position      <= '0;
        pmod          <= '0;
        saturated     <= 1'b0;
        overflow_seen <= 1'b0;
      end else if (saturated) begin
        overflow_seen <= 1'b1;
      end else if (position >= IDX_CAP) begin
        saturated <= 1'b1;
      end else begin
        position <= position + 1'b1;
        pmod     <= (pmod == KW'(SAMPLE_MAX - 1)) ? '0 : pmod + 1'b1;
      end
    end
  end

  // Window slots
  always_comb begin
    bank_ctl.take = take;
    bank_ctl.add  = !saturated;
    bank_ctl.last = seq_in.last_base;
    bank_ctl.load = !a_stall;
  end

  bocm_window_bank #(
    .SAMPLE_MAX (SAMPLE_MAX)
  ) u_bank (
    .clk          (clk),
    .rst          (rst),
    .ctl          (bank_ctl),
    .pmod         (pmod),
    .base         (seq_in.base),
    .len          (len),
    .sample_bases (sample_bases),
    .cand         (a_cand)
  );

  // Offer stage side-band
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_stall) begin
      a_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_last <= seq_in.last_base;
      a_ovf  <= overflow_seen || saturated;
      a_pos  <= position;
    end
  end

  // First tree level: best offer within each group of slots
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_c[g] = '0;
      for (int i = 0; i < bocm_pkg::GROUP; i++) begin
        if (g * bocm_pkg::GROUP + i < SAMPLE_MAX) begin
          grp_c[g] = bocm_pkg::cand_pick(grp_c[g], a_cand[g * bocm_pkg::GROUP + i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_stall) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!b_stall) begin
      b_last <= a_last;
      b_ovf  <= a_ovf;
      b_pos  <= a_pos;
      for (int g = 0; g < NG; g++) begin
        b_grp[g] <= grp_c[g];
      end
    end
  end

  // Second level and merge into the running best
  always_comb begin
    batch = '0;
    for (int g = 0; g < NG; g++) begin
      batch = bocm_pkg::cand_pick(batch, b_grp[g]);
    end
  end

  assign upd = b_valid && batch.valid && (!best_seen || (batch.score >= best_score));
  assign best_start_next = upd ? (b_pos - bocm_pkg::POS_W'(batch.k)) : best_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_seen  <= 1'b0;
      best_score <= '0;
      best_start <= '0;
    end else if (merge) begin
      if (b_last) begin
        best_seen  <= 1'b0;
        best_score <= '0;
        best_start <= '0;
      end else if (upd) begin
        best_seen  <= 1'b1;
        best_score <= batch.score;
        best_start <= best_start_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (merge && b_last) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge && b_last) begin
      res_index <= best_start_next;
      res_ovf   <= b_ovf;
    end
  end

  assign res_out.valid          = res_valid;
  assign res_out.best_index     = res_index;
  assign res_out.index_overflow = res_ovf;

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= IDX_CAP)
    else $error("position beyond index cap");

  a_sat_pos: assert property (@(posedge clk) disable iff (rst)
    saturated |-> (position == IDX_CAP))
    else $error("saturated below index cap");

  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !seq_in.ready |-> (res_valid && !res_out.ready))
    else $error("input stalled without a blocked result");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(b_valid && b_last))
    else $error("result without a final base");

  a_seq_clear: assert property (@(posedge clk) disable iff (rst)
    (take && seq_in.last_base) |=> ((position == '0) && !saturated && !overflow_seen))
    else $error("sequence state not cleared after final base");

endmodule
